// ===== rtl/rlsg_pkg.sv =====
// Shared types and constants for the rectified low-pass sub generator.
// Holds the payload structs, register indexes and fixed datapath widths.
// No dependencies.
`timescale 1ns / 1ps

package rlsg_pkg;

  // Fixed datapath widths
  localparam int SAMPLE_WIDTH = 24;  // audio samples, Q1.23
  localparam int FILT_W       = 32;  // filter internal values
  localparam int B0_W         = 30;  // b0, Q0.30 unsigned
  localparam int A2_W         = 30;  // a2, Q0.30 unsigned
  localparam int DRIVE_W      = 24;  // drive gain, Q8.16 unsigned
  localparam int LEVEL_W      = 20;  // sub level, Q4.16 unsigned
  localparam int CFG_IDX_W    = 3;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_B0     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_A1     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_A2     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DRIVE  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_LEVEL  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_BYPASS = 3'd5;

  // Register reset values (120 Hz at 48 kHz, unity drive, bypass on)
  localparam logic [B0_W-1:0]          B0_RESET    = 30'd65506;
  localparam logic signed [FILT_W-1:0] A1_RESET    = -32'sd2123626844;
  localparam logic [A2_W-1:0]          A2_RESET    = 30'd1050153000;
  localparam logic [DRIVE_W-1:0]       DRIVE_RESET = 24'd65536;
  localparam logic [LEVEL_W-1:0]       LEVEL_RESET = 20'd0;

  typedef struct packed {
    logic signed [SAMPLE_WIDTH-1:0] sample_in;
    logic                           end_of_block;
  } in_t;

  typedef struct packed {
    logic signed [SAMPLE_WIDTH-1:0] sample_out;
    logic                           end_of_block_out;
  } out_t;

endpackage

// ===== rtl/rectified_lowpass_sub_generator.sv =====
// Rectified low-pass sub generator: rectify, drive gain, two cascaded biquads, level.
// Uses rlsg_pkg for payload types, register indexes and widths.
`timescale 1ns / 1ps

// Usage
//   Input channel (in_valid/in_ready/in_data) takes one sample per transaction;
//   output channel (out_valid/out_ready/out_data) returns exactly one sample
//   per input, in order, with end_of_block copied through.
//   Configuration: cfg_we with cfg_index/cfg_data writes one register per
//   cycle; the user must write only while the block is idle, which the
//   block does not enforce. Any coefficient write clears the filter history.
//   Timing: one shared signed multiply-accumulate unit runs twelve products
//   under an 18-step sequencer for a filtered sample; a bypassed sample goes
//   straight to the final step. in_ready is low while a sample is in work,
//   so a new sample is taken only once the last has left its final step.
//   The next sample can be taken while a finished result still waits in the
//   output register.
//   Reset: registers return to their defaults (bypass on), history clears,
//   the output register empties.
//   Stall: if the receiver holds out_ready low, the finished sample waits in
//   its final step until the output register frees up.
module rectified_lowpass_sub_generator
  import rlsg_pkg::*;
#(
  parameter int COEF_WIDTH = 32
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  in_t                     in_data,
  output logic                    out_valid,
  input  logic                    out_ready,
  output out_t                    out_data,
  input  logic                    cfg_we,
  input  logic [CFG_IDX_W-1:0]    cfg_index,
  input  logic [((COEF_WIDTH > B0_W) ? COEF_WIDTH : B0_W)-1:0] cfg_data
);

  localparam int SW     = SAMPLE_WIDTH;
  localparam int AW     = (COEF_WIDTH > FILT_W) ? COEF_WIDTH : FILT_W;
  localparam int MW     = FILT_W + 1;   // multiplier operand width
  localparam int PW     = 2 * MW;       // product width
  localparam int ACC_W  = 64;

  // Sequencer steps
  localparam logic [4:0] S_GAIN   = 5'd0;
  localparam logic [4:0] S_RECT   = 5'd1;
  localparam logic [4:0] S1_T0    = 5'd2;
  localparam logic [4:0] S1_T1    = 5'd3;
  localparam logic [4:0] S1_T2    = 5'd4;
  localparam logic [4:0] S1_T3    = 5'd5;
  localparam logic [4:0] S1_T4    = 5'd6;
  localparam logic [4:0] S1_LAST  = 5'd7;
  localparam logic [4:0] S1_UPD   = 5'd8;
  localparam logic [4:0] S2_T0    = 5'd9;
  localparam logic [4:0] S2_T1    = 5'd10;
  localparam logic [4:0] S2_T2    = 5'd11;
  localparam logic [4:0] S2_T3    = 5'd12;
  localparam logic [4:0] S2_T4    = 5'd13;
  localparam logic [4:0] S2_LAST  = 5'd14;
  localparam logic [4:0] S2_UPD   = 5'd15;
  localparam logic [4:0] S_LEVEL  = 5'd16;
  localparam logic [4:0] S_DONE   = 5'd17;

  localparam logic signed [ACC_W-1:0] Y_MAX =
    {{(ACC_W-FILT_W+1){1'b0}}, {(FILT_W-1){1'b1}}};
  localparam logic signed [ACC_W-1:0] Y_MIN = ~Y_MAX;
  localparam logic signed [PW-1:0] P_MAX = {{(PW-SW+1){1'b0}}, {(SW-1){1'b1}}};
  localparam logic signed [PW-1:0] P_MIN = ~P_MAX;
  localparam logic signed [AW-1:0] A1_MAX = {{(AW-FILT_W+1){1'b0}}, {(FILT_W-1){1'b1}}};
  localparam logic signed [AW-1:0] A1_MIN = ~A1_MAX;

  // Configuration registers
  logic [B0_W-1:0]          b0;
  logic signed [FILT_W-1:0] a1;
  logic [A2_W-1:0]          a2;
  logic [DRIVE_W-1:0]       drive_gain;
  logic [LEVEL_W-1:0]       sub_level;
  logic                     bypass;

  // Filter history
  logic signed [SW-1:0]     fx0, fx1;
  logic signed [FILT_W-1:0] fy0, fy1, sx0, sx1, sy0, sy1;

  // Sequencer and datapath
  logic                     busy;
  logic [4:0]               step;
  logic                     byp_item;
  logic                     eob;
  logic signed [SW-1:0]     x_hold;
  logic signed [SW-1:0]     r;
  logic signed [PW-1:0]     prod;
  logic signed [ACC_W-1:0]  acc;

  logic signed [MW-1:0]     mul_a, mul_b;
  logic signed [SW:0]       x_ext, mag;
  logic signed [ACC_W-1:0]  term, y_shift;
  logic signed [FILT_W-1:0] y_sat;
  logic signed [PW-1:0]     p_shift;
  logic signed [SW-1:0]     s_sat;
  logic signed [COEF_WIDTH-1:0] a1_raw;
  logic signed [AW-1:0]     a1_ext;
  logic signed [FILT_W-1:0] a1_sat;
  logic                     out_free;

  assign in_ready = !busy;
  assign out_free = !out_valid || out_ready;

  // Rectify the held sample
  assign x_ext = (SW+1)'(x_hold);
  assign mag   = x_hold[SW-1] ? -x_ext : x_ext;

  // Floor each biquad product to Q.45 before it enters the sum
  assign term = ACC_W'(prod >>> 8);

  // Floor the sum to Q.23 and saturate to the filter width
  assign y_shift = acc >>> 22;
  assign y_sat   = (y_shift > Y_MAX) ? FILT_W'(Y_MAX) :
                   (y_shift < Y_MIN) ? FILT_W'(Y_MIN) : FILT_W'(y_shift);

  // Drop 16 fraction bits of a gain or level product, saturate to a sample
  assign p_shift = prod >>> 16;
  assign s_sat   = (p_shift > P_MAX) ? SW'(P_MAX) :
                   (p_shift < P_MIN) ? SW'(P_MIN) : SW'(p_shift);

  // Clamp a1 to the filter width on write
  assign a1_raw = cfg_data[COEF_WIDTH-1:0];
  assign a1_ext = AW'(a1_raw);
  assign a1_sat = (a1_ext > A1_MAX) ? FILT_W'(A1_MAX) :
                  (a1_ext < A1_MIN) ? FILT_W'(A1_MIN) : FILT_W'(a1_ext);

  // Select multiplier operands for the current step
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (step)
      S_GAIN: begin
        mul_a = MW'(mag);
        mul_b = MW'(drive_gain);
      end
      S1_T0: begin
        mul_a = MW'(r);
        mul_b = MW'(b0);
      end
      S1_T1: begin
        mul_a = MW'(fx0);
        mul_b = MW'({b0, 1'b0});
      end
      S1_T2: begin
        mul_a = MW'(fx1);
        mul_b = MW'(b0);
      end
      S1_T3: begin
        mul_a = MW'(fy0);
        mul_b = MW'(a1);
      end
      S1_T4: begin
        mul_a = MW'(fy1);
        mul_b = MW'(a2);
      end
      S2_T0: begin
        mul_a = MW'(fy0);
        mul_b = MW'(b0);
      end
      S2_T1: begin
        mul_a = MW'(sx0);
        mul_b = MW'({b0, 1'b0});
      end
      S2_T2: begin
        mul_a = MW'(sx1);
        mul_b = MW'(b0);
      end
      S2_T3: begin
        mul_a = MW'(sy0);
        mul_b = MW'(a1);
      end
      S2_T4: begin
        mul_a = MW'(sy1);
        mul_b = MW'(a2);
      end
      S_LEVEL: begin
        mul_a = MW'(sy0);
        mul_b = MW'(sub_level);
      end
      default: ;
    endcase
  end

  // Shared multiplier and accumulator; hold the level product in the final step
  always_ff @(posedge clk) begin
    if (step != S_DONE) begin
      prod <= mul_a * mul_b;
    end
    case (step) inside
      S1_T1, S2_T1:                   acc <= term;
      S1_T2, S1_T3, S2_T2, S2_T3:     acc <= acc + term;
      S1_T4, S1_LAST, S2_T4, S2_LAST: acc <= acc - term;
      default: ;
    endcase
    if (busy && step == S_RECT) begin
      r <= s_sat;
    end
    if (in_valid && in_ready) begin
      x_hold <= in_data.sample_in;
      eob    <= in_data.end_of_block;
    end
  end

  // Sequencer, history, configuration and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      busy       <= 1'b0;
      step       <= S_GAIN;
      byp_item   <= 1'b0;
      out_valid  <= 1'b0;
      b0         <= B0_RESET;
      a1         <= A1_RESET;
      a2         <= A2_RESET;
      drive_gain <= DRIVE_RESET;
      sub_level  <= LEVEL_RESET;
      bypass     <= 1'b1;
      fx0 <= '0; fx1 <= '0; fy0 <= '0; fy1 <= '0;
      sx0 <= '0; sx1 <= '0; sy0 <= '0; sy1 <= '0;
    end else begin
      // Drain the output register unless a new result loads it
      if (out_valid && out_ready && !(busy && step == S_DONE)) begin
        out_valid <= 1'b0;
      end

      // Start a transaction; bypass goes straight to the final step
      if (in_valid && in_ready) begin
        busy     <= 1'b1;
        byp_item <= bypass;
        step     <= bypass ? S_DONE : S_GAIN;
      end

      if (busy) begin
        if (step == S_DONE) begin
          // Hold until the output register is free
          if (out_free) begin
            out_data.sample_out       <= byp_item ? x_hold : s_sat;
            out_data.end_of_block_out <= eob;
            out_valid                 <= 1'b1;
            busy                      <= 1'b0;
          end
        end else begin
          step <= step + 5'd1;
        end

        // Advance the history of each stage
        if (step == S1_UPD) begin
          fx1 <= fx0;
          fx0 <= r;
          fy1 <= fy0;
          fy0 <= y_sat;
        end
        if (step == S2_UPD) begin
          sx1 <= sx0;
          sx0 <= fy0;
          sy1 <= sy0;
          sy0 <= y_sat;
        end
      end

      // Register writes; coefficient writes clear the history
      if (cfg_we) begin
        unique case (cfg_index)
          REG_B0:     b0         <= cfg_data[B0_W-1:0];
          REG_A1:     a1         <= a1_sat;
          REG_A2:     a2         <= cfg_data[A2_W-1:0];
          REG_DRIVE:  drive_gain <= cfg_data[DRIVE_W-1:0];
          REG_LEVEL:  sub_level  <= cfg_data[LEVEL_W-1:0];
          REG_BYPASS: bypass     <= cfg_data[0];
          default: ;
        endcase
        if (cfg_index == REG_B0 || cfg_index == REG_A1 || cfg_index == REG_A2) begin
          fx0 <= '0; fx1 <= '0; fy0 <= '0; fy1 <= '0;
          sx0 <= '0; sx1 <= '0; sy0 <= '0; sy1 <= '0;
        end
      end
    end
  end

endmodule
